// ===== sv/stable_sorted_priority_queue_assert.svh =====
// Assertion macros for the sorted priority queue
`ifndef STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SSPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SSPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sspq_pkg.sv =====
// Shared types and constants for the sorted priority queue
package sspq_pkg;

  localparam int ID_W     = 16;
  localparam int SCORE_W  = 32;
  localparam int DATA_W   = 48;
  localparam int OUSER_W  = 3;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // out_tuser bit positions
  localparam int OU_VALID = 0;
  localparam int OU_EMPTY = 1;
  localparam int OU_DROP  = 2;

  typedef struct packed {
    logic load;   // capture a result this cycle
    logic enq;    // insert the incoming entry
    logic deq;    // remove the head entry
    logic drop;   // enqueue refused, queue full
  } sspq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sspq_stat_t;

endpackage

// ===== sv/stable_sorted_priority_queue.sv =====
// Top level of the bounded, stable, sorted max-priority queue
//
// Input stream (in_*): one transaction per request. in_tuser is the request
// kind (0 enqueue, 1 dequeue); in_tdata carries the entry id and score.
// Result stream (out_*): exactly one transaction per request, in order.
// out_tdata carries the dequeued id and score (zero when nothing came out);
// out_tuser carries the returned, empty-after and dropped flags.
// Entries are held sorted by descending score in DEPTH slot registers; equal
// scores leave in arrival order. An enqueue into a full queue is dropped.
// The result is registered and presented in the cycle after the request is taken.
// Throughput: one request per cycle while the receiver does not stall; every slot
// compares against the new score at once and the whole row shifts in the same cycle.
// A held result does not block the input while out_tready is high; when the
// receiver stalls, the result is held and in_tready drops until it is taken.
// Reset (rst_n low, synchronous) empties the queue and clears any held result.
`include "stable_sorted_priority_queue_assert.svh"

module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [DATA_W-1:0]  in_tdata,   // [15:0] entry_id, [47:16] entry_score
  input  logic               in_tuser,   // [0] req_type
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [DATA_W-1:0]  out_tdata,  // [15:0] out_id, [47:16] out_score
  output logic [OUSER_W-1:0] out_tuser   // [0] out_valid, [1] is_empty, [2] dropped
);

  sspq_cmd_t                 cmd;
  sspq_stat_t                stat;
  logic [ID_W-1:0]           res_id;
  logic signed [SCORE_W-1:0] res_score;
  logic                      res_valid;
  logic                      res_empty;
  logic                      res_drop;
  logic                      deq_live;   // dequeue taken from a non-empty queue
  logic                      out_drop;   // presented result flags a refusal

  sspq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_req     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sspq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_id     (in_tdata[ID_W-1:0]),
    .in_score  (in_tdata[ID_W+SCORE_W-1:ID_W]),
    .stat      (stat),
    .res_id    (res_id),
    .res_score (res_score),
    .res_valid (res_valid),
    .res_empty (res_empty),
    .res_drop  (res_drop)
  );

  assign out_tdata = {res_score, res_id};
  assign out_tuser = {res_drop, res_empty, res_valid};

  assign deq_live = in_tvalid && in_tready && (in_tuser == REQ_DEQ) && !stat.empty;
  assign out_drop = out_tvalid && out_tuser[OU_DROP];

  `SSPQ_ASSERT_NXT(a_deq_ret, deq_live, out_tvalid && out_tuser[OU_VALID], "lost dequeue")
  `SSPQ_ASSERT_IMP(a_drop_full, out_drop, stat.full && !out_tuser[OU_VALID], "bad drop")
  `SSPQ_ASSERT_IMP(a_empty, out_tvalid, out_tuser[OU_EMPTY] == stat.empty, "empty flag mismatch")

endmodule

// ===== sv/sspq_ctrl.sv =====
// Controller: handshake and operation decode for the sorted priority queue
module sspq_ctrl
  import sspq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_req,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  sspq_stat_t stat,
  output sspq_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_tready  = (state_r == ST_IDLE) || out_tready;
  assign out_tvalid = (state_r == ST_HOLD);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    cmd.load = accept;
    cmd.enq  = accept && (in_req == REQ_ENQ) && !stat.full;
    cmd.drop = accept && (in_req == REQ_ENQ) && stat.full;
    cmd.deq  = accept && (in_req == REQ_DEQ) && !stat.empty;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) state_nxt = ST_HOLD;
        else if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/sspq_dpath.sv =====
// Datapath: sorted slot array and result register
module sspq_dpath
  import sspq_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  sspq_cmd_t                 cmd,
  input  logic [ID_W-1:0]           in_id,
  input  logic signed [SCORE_W-1:0] in_score,
  output sspq_stat_t                stat,
  output logic [ID_W-1:0]           res_id,
  output logic signed [SCORE_W-1:0] res_score,
  output logic                      res_valid,
  output logic                      res_empty,
  output logic                      res_drop
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [ID_W-1:0]           id_r    [DEPTH];
  logic signed [SCORE_W-1:0] score_r [DEPTH];
  logic [ID_W-1:0]           id_nxt  [DEPTH];
  logic signed [SCORE_W-1:0] score_nxt [DEPTH];
  logic [OCC_W-1:0]          occ_r;
  logic [OCC_W-1:0]          occ_nxt;
  logic [DEPTH-1:0]          stay;

  assign stat.full  = (occ_r == OCC_W'(DEPTH));
  assign stat.empty = (occ_r == '0);

  // stay[i]: slot i holds a live entry scoring at least the newcomer,
  // so ties keep the older entry in front
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      stay[i] = (OCC_W'(i) < occ_r) && (score_r[i] >= in_score);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      id_nxt[i]    = id_r[i];
      score_nxt[i] = score_r[i];
      if (cmd.enq) begin
        if (!stay[i]) begin
          if (i == 0) begin
            id_nxt[i]    = in_id;
            score_nxt[i] = in_score;
          end else if (stay[i-1]) begin
            id_nxt[i]    = in_id;
            score_nxt[i] = in_score;
          end else begin
            id_nxt[i]    = id_r[i-1];
            score_nxt[i] = score_r[i-1];
          end
        end
      end else if (cmd.deq) begin
        if (i < DEPTH - 1) begin
          id_nxt[i]    = id_r[i+1];
          score_nxt[i] = score_r[i+1];
        end
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.enq) occ_nxt = occ_r + OCC_W'(1);
    else if (cmd.deq) occ_nxt = occ_r - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      id_r[i]    <= id_nxt[i];
      score_r[i] <= score_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_valid <= cmd.deq;
      res_id    <= cmd.deq ? id_r[0] : '0;
      res_score <= cmd.deq ? score_r[0] : '0;
      res_drop  <= cmd.drop;
      // enqueue always leaves something behind; dequeue empties at one entry or less
      res_empty <= cmd.enq || cmd.drop ? 1'b0 : (occ_r <= OCC_W'(1));
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the stable sorted priority queue
`timescale 1ns / 100ps

module tb_top;
  import sspq_pkg::*;

  localparam int PQ_DEPTH    = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYC  = 5;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } pq_entry_t;

  typedef struct packed {
    logic                      returned;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    logic                      empty;
    logic                      dropped;
  } pq_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [DATA_W-1:0]  in_tdata;   // [15:0] entry_id, [47:16] entry_score
  logic               in_tuser;   // [0] req_type
  logic               out_tvalid;
  logic               out_tready;
  logic [DATA_W-1:0]  out_tdata;  // [15:0] out_id, [47:16] out_score
  logic [OUSER_W-1:0] out_tuser;  // [0] out_valid, [1] is_empty, [2] dropped

  pq_entry_t  pq_entries[$];
  pq_result_t pending_results[$];
  int         mismatch_count;
  int         cycle_count;
  int         hold_cycles_req;
  bit         idle_en;

  stable_sorted_priority_queue #(.DEPTH(PQ_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Scores bunched so that ties and the signed extremes turn up often
  function automatic logic [SCORE_W-1:0] pick_score();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SCORE_W'($signed($urandom_range(0, 7)) - 4);
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h8000_0001;
        default: return 32'h7fff_fffe;
      endcase
    end
    return $urandom;
  endfunction

  // Sorted by descending score, new entry after any of equal score
  function automatic pq_result_t predict_result(logic req, logic [ID_W-1:0] id,
                                                logic [SCORE_W-1:0] score);
    pq_result_t r;
    pq_entry_t  e;
    int         pos;
    r = '0;
    if (req == REQ_ENQ) begin
      if (pq_entries.size() >= PQ_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < pq_entries.size() &&
               $signed(pq_entries[pos].score) >= $signed(score))
          pos++;
        e.id    = id;
        e.score = score;
        pq_entries.insert(pos, e);
      end
    end else if (pq_entries.size() > 0) begin
      r.returned = 1'b1;
      r.id       = pq_entries[0].id;
      r.score    = pq_entries[0].score;
      void'(pq_entries.pop_front());
    end
    r.empty = (pq_entries.size() == 0);
    return r;
  endfunction

  // Valid is left high after acceptance; it drops only for a gap or a pause
  task automatic send_request(logic req, logic [ID_W-1:0] id, logic [SCORE_W-1:0] score);
    int gap;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      gap = gap_len();
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {score, id};
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_result(req, id, score));
  endtask

  task automatic enqueue(logic [ID_W-1:0] id, logic [SCORE_W-1:0] score);
    send_request(REQ_ENQ, id, score);
  endtask

  // id and score are don't-care on a dequeue, so keep them random
  task automatic dequeue();
    send_request(REQ_DEQ, ID_W'($urandom), $urandom);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    idle_en = 1'b0;
    dequeue();                           // empty queue
    enqueue(16'h0000, 32'h8000_0000);
    enqueue(16'hffff, 32'h7fff_ffff);
    enqueue(16'h1234, 32'h0000_0000);
    enqueue(16'h00a5, 32'hffff_ffff);
    enqueue(16'h5a5a, 32'h0000_0000);    // tie, behind 1234
    enqueue(16'ha5a5, 32'h0000_0000);
    enqueue(16'h8001, 32'h7fff_ffff);    // tie with the maximum
    repeat (8) dequeue();                // last one finds it empty
    wait_drained();
  endtask

  task automatic test_fill_and_drop();
    idle_en = 1'b1;
    repeat (PQ_DEPTH + 3) enqueue(ID_W'($urandom), pick_score());
    dequeue();
    enqueue(ID_W'($urandom), pick_score());
    enqueue(ID_W'($urandom), pick_score());   // full again, refused
    repeat (PQ_DEPTH + 1) dequeue();
    wait_drained();
  endtask

  // Receiver stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_cycles_req = 300;
    repeat (30) begin
      if ($urandom_range(0, 99) < 80) enqueue(ID_W'($urandom), pick_score());
      else dequeue();
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(int n_items, int enq_pct, bit with_idle);
    idle_en = with_idle;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < enq_pct) enqueue(ID_W'($urandom), pick_score());
      else dequeue();
    end
    wait_drained();
  endtask

  // Result checker
  always @(posedge clk) begin
    pq_result_t exp_r;
    pq_result_t got_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_r.returned = out_tuser[OU_VALID];
      got_r.id       = out_tdata[ID_W-1:0];
      got_r.score    = out_tdata[ID_W +: SCORE_W];
      got_r.empty    = out_tuser[OU_EMPTY];
      got_r.dropped  = out_tuser[OU_DROP];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: ret=%0b id=%h score=%0d empty=%0b drop=%0b",
                   got_r.returned, got_r.id, got_r.score, got_r.empty, got_r.dropped);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.returned !== exp_r.returned || got_r.id !== exp_r.id ||
            got_r.score !== exp_r.score || got_r.empty !== exp_r.empty ||
            got_r.dropped !== exp_r.dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp ret=%0b id=%h score=%0d empty=%0b drop=%0b",
                     exp_r.returned, exp_r.id, exp_r.score, exp_r.empty, exp_r.dropped);
            $display("          got ret=%0b id=%h score=%0d empty=%0b drop=%0b",
                     got_r.returned, got_r.id, got_r.score, got_r.empty, got_r.dropped);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when a test asks for one
  initial begin
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        n = gap_len();
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    mismatch_count  = 0;
    hold_cycles_req = 0;
    idle_en         = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_ENQ;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drop();
    test_backpressure();
    test_random_traffic(160, 70, 1'b1);   // mostly full, many refusals
    test_random_traffic(150, 50, 1'b0);
    test_random_traffic(150, 30, 1'b1);   // often empty

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
